[hdl/tls_pkg.sv]
// Shared types, constants and helper functions for the two-way traffic light sequencer.
// Used by the configuration bank, the sequencer core, the top level and the checker.
// No dependencies.
package tls_pkg;

  // configuration register indexes
  localparam int unsigned CFG_COUNT = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_A_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_B_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_THRESH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PER_CNT = 2'd3;

  // register reset values
  localparam logic [6:0] RST_PHASE_A_START   = 7'd15;
  localparam logic [6:0] RST_PHASE_B_START   = 7'd23;
  localparam logic [6:0] RST_YELLOW_THRESH   = 7'd3;
  localparam logic [7:0] RST_REFRESH_PER_CNT = 8'd50;

  // lamp patterns: bit0 W red, bit1 W green, bit2 W yellow, bit3 S red, bit4 S green, bit5 S yellow
  localparam logic [5:0] LAMPS_OFF      = 6'h00;
  localparam logic [5:0] LAMPS_A_GREEN  = 6'h11;
  localparam logic [5:0] LAMPS_A_YELLOW = 6'h21;
  localparam logic [5:0] LAMPS_B_GREEN  = 6'h0A;
  localparam logic [5:0] LAMPS_B_YELLOW = 6'h0C;

  // sequencer phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_MAN_A  = 5'b00010,
    PH_MAN_B  = 5'b00100,
    PH_AUTO_A = 5'b01000,
    PH_AUTO_B = 5'b10000
  } phase_t;

  // configuration bank contents
  typedef struct packed {
    logic [6:0] phase_a_start;
    logic [6:0] phase_b_start;
    logic [6:0] yellow_threshold;
    logic [7:0] refreshes_per_count;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic [5:0] lamps;
    logic [3:0] digit_value;
    logic       digit_select;
    logic       display_active;
  } result_t;

  // outcome of one display refresh step
  typedef struct packed {
    logic [6:0] count;
    logic [7:0] refresh;
    logic       digit_phase;
    logic [3:0] digit;
    logic       select;
    logic       done;
  } adv_t;

  // tens digit by reciprocal multiply, exact for all 7-bit values
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] prod;
    prod = {8'd0, v} * 15'd205;
    return prod[14:11];
  endfunction

  // units digit as remainder after the tens
  function automatic logic [3:0] units_of(input logic [6:0] v);
    logic [6:0] t10;
    logic [6:0] rem;
    t10 = {3'd0, tens_of(v)} * 7'd10;
    rem = v - t10;
    return rem[3:0];
  endfunction

  // show one digit, advance refresh and count timing
  function automatic adv_t show_advance(input logic [6:0] count, input logic [7:0] refresh,
                                        input logic digit_phase, input logic [7:0] limit);
    adv_t       r;
    logic [7:0] refresh_inc;
    r.count       = count;
    r.refresh     = refresh;
    r.digit_phase = ~digit_phase;
    r.select      = digit_phase;
    r.digit       = digit_phase ? tens_of(count) : units_of(count);
    r.done        = 1'b0;
    refresh_inc   = refresh + 8'd1;
    if (digit_phase) begin
      if (refresh_inc >= limit) begin
        r.refresh = 8'd0;
        if (count == 7'd0) begin
          r.done = 1'b1;
        end else begin
          r.count = count - 7'd1;
        end
      end else begin
        r.refresh = refresh_inc;
      end
    end
    return r;
  endfunction

endpackage

[hdl/tls_ifc.sv]
// Valid/ready channel interfaces for tick beats in and lamp/display beats out.
// Depends on nothing but plain logic types.
interface tls_in_if;
  logic valid;
  logic ready;
  logic auto_switch;
  logic button_press;

  modport source (output valid, output auto_switch, output button_press, input ready);
  modport sink (input valid, input auto_switch, input button_press, output ready);
endinterface

interface tls_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] lamps;
  logic [3:0] digit_value;
  logic       digit_select;
  logic       display_active;

  modport source (output valid, output lamps, output digit_value, output digit_select,
                  output display_active, input ready);
  modport sink (input valid, input lamps, input digit_value, input digit_select,
                input display_active, output ready);
endinterface

[hdl/tls_cfg.sv]
// Configuration register bank for the traffic light sequencer.
// Depends on tls_pkg for indexes, reset values and the cfg_t bundle.
module tls_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tls_pkg::cfg_t                  cfg
);

  tls_pkg::cfg_t cfg_r;
  tls_pkg::cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tls_pkg::REG_PHASE_A_START:   cfg_nxt.phase_a_start       = cfg_wdata[6:0];
        tls_pkg::REG_PHASE_B_START:   cfg_nxt.phase_b_start       = cfg_wdata[6:0];
        tls_pkg::REG_YELLOW_THRESH:   cfg_nxt.yellow_threshold    = cfg_wdata[6:0];
        tls_pkg::REG_REFRESH_PER_CNT: cfg_nxt.refreshes_per_count = cfg_wdata;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  // register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_a_start       <= tls_pkg::RST_PHASE_A_START;
      cfg_r.phase_b_start       <= tls_pkg::RST_PHASE_B_START;
      cfg_r.yellow_threshold    <= tls_pkg::RST_YELLOW_THRESH;
      cfg_r.refreshes_per_count <= tls_pkg::RST_REFRESH_PER_CNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/tls_seq.sv]
// Sequencer core: phase, countdown, display multiplex and lamp state, one tick per step.
// Depends on tls_pkg for phase_t, cfg_t, result_t and the display helper functions.
module tls_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              auto_switch,
  input  logic              button_press,
  input  tls_pkg::cfg_t     cfg,
  output tls_pkg::result_t  result
);

  // manual step codes
  localparam logic [2:0] STEP_A_GREEN  = 3'd1;
  localparam logic [2:0] STEP_A_YELLOW = 3'd2;
  localparam logic [2:0] STEP_B_GREEN  = 3'd3;
  localparam logic [2:0] STEP_LAST     = 3'd4;

  tls_pkg::phase_t phase_r, phase_nxt;
  logic [6:0]      count_r, count_nxt;
  logic [7:0]      refresh_r, refresh_nxt;
  logic            dphase_r, dphase_nxt;
  logic [2:0]      mstep_r, mstep_nxt;
  logic [5:0]      lamp_r, lamp_nxt;

  logic [7:0]       limit;
  tls_pkg::adv_t    adv;
  tls_pkg::result_t res;

  assign limit = (cfg.refreshes_per_count == 8'd0) ? 8'd1 : cfg.refreshes_per_count;

  // next state for one tick
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    refresh_nxt = refresh_r;
    dphase_nxt  = dphase_r;
    mstep_nxt   = mstep_r;
    lamp_nxt    = lamp_r;
    res         = '0;
    adv         = '0;

    if (auto_switch) begin
      // entering auto: finish any manual countdown, start the A phase
      if (phase_nxt != tls_pkg::PH_AUTO_A && phase_nxt != tls_pkg::PH_AUTO_B) begin
        if (phase_nxt == tls_pkg::PH_MAN_A) begin
          mstep_nxt = STEP_B_GREEN;
        end else if (phase_nxt == tls_pkg::PH_MAN_B) begin
          mstep_nxt = STEP_A_GREEN;
        end
        phase_nxt   = tls_pkg::PH_AUTO_A;
        count_nxt   = cfg.phase_a_start;
        refresh_nxt = 8'd0;
        dphase_nxt  = 1'b0;
      end
      if (phase_nxt == tls_pkg::PH_AUTO_A) begin
        lamp_nxt = (count_nxt <= cfg.yellow_threshold) ? tls_pkg::LAMPS_A_YELLOW
                                                       : tls_pkg::LAMPS_A_GREEN;
      end else begin
        lamp_nxt = (count_nxt <= cfg.yellow_threshold) ? tls_pkg::LAMPS_B_YELLOW
                                                       : tls_pkg::LAMPS_B_GREEN;
      end
      adv                = tls_pkg::show_advance(count_nxt, refresh_nxt, dphase_nxt, limit);
      count_nxt          = adv.count;
      refresh_nxt        = adv.refresh;
      dphase_nxt         = adv.digit_phase;
      res.digit_value    = adv.digit;
      res.digit_select   = adv.select;
      res.display_active = 1'b1;
      // countdown over: swap to the other direction
      if (adv.done) begin
        phase_nxt   = (phase_nxt == tls_pkg::PH_AUTO_A) ? tls_pkg::PH_AUTO_B
                                                        : tls_pkg::PH_AUTO_A;
        count_nxt   = (phase_nxt == tls_pkg::PH_AUTO_A) ? cfg.phase_a_start
                                                        : cfg.phase_b_start;
        refresh_nxt = 8'd0;
        dphase_nxt  = 1'b0;
      end
    end else begin
      // leaving auto blanks the lamps
      if (phase_nxt == tls_pkg::PH_AUTO_A || phase_nxt == tls_pkg::PH_AUTO_B) begin
        lamp_nxt  = tls_pkg::LAMPS_OFF;
        phase_nxt = tls_pkg::PH_IDLE;
      end
      // manual press steps the sequence
      if (phase_nxt == tls_pkg::PH_IDLE && button_press) begin
        mstep_nxt = (mstep_nxt >= STEP_LAST) ? STEP_A_GREEN : mstep_nxt + 3'd1;
        case (mstep_nxt)
          STEP_A_GREEN: lamp_nxt = tls_pkg::LAMPS_A_GREEN;
          STEP_B_GREEN: lamp_nxt = tls_pkg::LAMPS_B_GREEN;
          STEP_A_YELLOW: begin
            phase_nxt   = tls_pkg::PH_MAN_A;
            count_nxt   = cfg.yellow_threshold;
            refresh_nxt = 8'd0;
            dphase_nxt  = 1'b0;
          end
          default: begin
            phase_nxt   = tls_pkg::PH_MAN_B;
            count_nxt   = cfg.yellow_threshold;
            refresh_nxt = 8'd0;
            dphase_nxt  = 1'b0;
          end
        endcase
      end
      // timed manual yellow
      if (phase_nxt == tls_pkg::PH_MAN_A || phase_nxt == tls_pkg::PH_MAN_B) begin
        lamp_nxt = (phase_nxt == tls_pkg::PH_MAN_A) ? tls_pkg::LAMPS_A_YELLOW
                                                    : tls_pkg::LAMPS_B_YELLOW;
        adv                = tls_pkg::show_advance(count_nxt, refresh_nxt, dphase_nxt, limit);
        count_nxt          = adv.count;
        refresh_nxt        = adv.refresh;
        dphase_nxt         = adv.digit_phase;
        res.digit_value    = adv.digit;
        res.digit_select   = adv.select;
        res.display_active = 1'b1;
        if (adv.done) begin
          if (phase_nxt == tls_pkg::PH_MAN_A) begin
            mstep_nxt = STEP_B_GREEN;
            lamp_nxt  = tls_pkg::LAMPS_B_GREEN;
          end else begin
            mstep_nxt = STEP_A_GREEN;
            lamp_nxt  = tls_pkg::LAMPS_A_GREEN;
          end
          phase_nxt = tls_pkg::PH_IDLE;
        end
      end
    end
    res.lamps = lamp_nxt;
  end

  // state registers, updated once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= tls_pkg::PH_IDLE;
      count_r   <= 7'd0;
      refresh_r <= 8'd0;
      dphase_r  <= 1'b0;
      mstep_r   <= 3'd0;
      lamp_r    <= tls_pkg::LAMPS_OFF;
    end else if (step) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      refresh_r <= refresh_nxt;
      dphase_r  <= dphase_nxt;
      mstep_r   <= mstep_nxt;
      lamp_r    <= lamp_nxt;
    end
  end

  assign result = res;

endmodule

[hdl/two_way_traffic_light_sequencer_top.sv]
// Top level of the two-way traffic light sequencer: tick input register, core, result register.
// Depends on tls_pkg, tls_ifc.sv, tls_cfg and tls_seq.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------------------------
//  in_if   | in  | valid/ready | auto_switch, button_press
//  out_if  | out | valid/ready | lamps, digit_value, digit_select, display_active
//  cfg_*   | in  | cfg_we      | cfg_index (2 b), cfg_wdata (8 b)
//
// One tick beat is taken every cycle while in_if.ready is high; its result passes the tick
// register, then the result register (two register stages).
// Reset is synchronous on rst_n: lamps off, manual idle, both registers empty.
// When out_if.ready is low with a result waiting, the result register holds and the tick register fills,
// after which in_if.ready drops until the result is taken.
module two_way_traffic_light_sequencer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  tls_in_if.sink                         in_if,
  tls_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tls_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tls_pkg::cfg_t    cfg;
  tls_pkg::result_t result;

  logic             tick_valid_r;
  logic             tick_auto_r;
  logic             tick_press_r;
  logic             out_valid_r;
  tls_pkg::result_t out_r;
  logic             out_free;
  logic             step;

  // handshake control
  assign out_free    = !out_valid_r || out_if.ready;
  assign step        = tick_valid_r && out_free;
  assign in_if.ready = !tick_valid_r || out_free;

  tls_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tls_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .auto_switch  (tick_auto_r),
    .button_press (tick_press_r),
    .cfg          (cfg),
    .result       (result)
  );

  // tick register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      tick_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      tick_auto_r  <= in_if.auto_switch;
      tick_press_r <= in_if.button_press;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= tick_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.lamps          = out_r.lamps;
  assign out_if.digit_value    = out_r.digit_value;
  assign out_if.digit_select   = out_r.digit_select;
  assign out_if.display_active = out_r.display_active;

endmodule

[hdl/tls_checker.sv]
// Port-level checks for the traffic light sequencer, attached to the top level by bind.
// Depends on tls_pkg for the lamp patterns and on the top level's ports.
module tls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] lamps,
  input logic [3:0] digit_value,
  input logic       digit_select,
  input logic       display_active
);

  // a stalled result beat holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(lamps) && $stable(digit_value)
      && $stable(digit_select) && $stable(display_active))
    else $error("result beat changed while stalled");

  // a held display shows digit zero on the units position
  a_held_display: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !display_active |-> digit_value == 4'd0 && !digit_select)
    else $error("held display drives a digit");

  // lamps only ever show one of the defined patterns
  a_lamp_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> lamps == tls_pkg::LAMPS_OFF || lamps == tls_pkg::LAMPS_A_GREEN
      || lamps == tls_pkg::LAMPS_A_YELLOW || lamps == tls_pkg::LAMPS_B_GREEN
      || lamps == tls_pkg::LAMPS_B_YELLOW)
    else $error("undefined lamp pattern");

  // units digit is always a decimal digit
  a_units_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !digit_select |-> digit_value <= 4'd9)
    else $error("units digit out of range");

  // no result beat straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind two_way_traffic_light_sequencer_top tls_checker u_tls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .lamps          (out_if.lamps),
  .digit_value    (out_if.digit_value),
  .digit_select   (out_if.digit_select),
  .display_active (out_if.display_active)
);
